// ----- rtl/ams_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the AND addressing-mode sequencer.
// No dependencies; imported by ams_step and the top-level module.
package ams_pkg;

  localparam logic [15:0] HI_MASK = 16'hFF00;
  localparam logic [15:0] LO_MASK = 16'h00FF;
  localparam logic [15:0] NO_ADDR = 16'h0000;

  typedef enum logic [2:0] {
    MODE_IMM  = 3'd0,
    MODE_ZP   = 3'd1,
    MODE_ZPX  = 3'd2,
    MODE_ABS  = 3'd3,
    MODE_ABSX = 3'd4,
    MODE_ABSY = 3'd5,
    MODE_INDX = 3'd6,
    MODE_INDY = 3'd7
  } mode_t;

  // Sequencer step, one-hot
  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_OPND1   = 8'b0000_0010,  // first operand byte due
    ST_ISSUE   = 8'b0000_0100,  // issue eff_addr after dummy cycle
    ST_ABS_HI  = 8'b0000_1000,  // absolute high byte due
    ST_INDX_DM = 8'b0001_0000,  // (zp,X) dummy cycle done
    ST_PTR_LO  = 8'b0010_0000,
    ST_PTR_HI  = 8'b0100_0000,
    ST_OPERAND = 8'b1000_0000
  } step_t;

  typedef struct packed {
    logic        start_req;
    logic [2:0]  mode;
    logic [15:0] pc;
    logic [7:0]  x_index;
    logic [7:0]  y_index;
    logic [7:0]  acc_in;
    logic [7:0]  bus_data;
  } in_item_t;

  typedef struct packed {
    logic [15:0] bus_addr;
    logic        pc_advance;
    logic        done_res;
    logic [7:0]  acc_out;
    logic        neg_flag;
    logic        zero_flag;
    logic        page_crossed;
  } out_item_t;

  typedef struct packed {
    step_t       step;
    mode_t       mode_latch;
    logic [15:0] eff_addr;
    logic [7:0]  pointer_word;  // always a page-zero pointer
    logic        crossed_latch;
  } seq_state_t;

  localparam seq_state_t STATE_RESET = '{
    step: ST_IDLE, mode_latch: MODE_IMM, eff_addr: 16'h0000,
    pointer_word: 8'h00, crossed_latch: 1'b0
  };

endpackage

// ----- rtl/ams_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the sequencer's input and result streams.
// Depends on ams_pkg for nothing but shares field widths with it.
interface ams_in_if;
  logic        valid;
  logic        ready;
  logic        start_req;
  logic [2:0]  mode;
  logic [15:0] pc;
  logic [7:0]  x_index;
  logic [7:0]  y_index;
  logic [7:0]  acc_in;
  logic [7:0]  bus_data;

  modport source (output valid, start_req, mode, pc, x_index, y_index, acc_in, bus_data,
                  input ready);
  modport sink (input valid, start_req, mode, pc, x_index, y_index, acc_in, bus_data,
                output ready);
endinterface

interface ams_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] bus_addr;
  logic        pc_advance;
  logic        done_res;
  logic [7:0]  acc_out;
  logic        neg_flag;
  logic        zero_flag;
  logic        page_crossed;

  modport source (output valid, bus_addr, pc_advance, done_res, acc_out, neg_flag,
                  zero_flag, page_crossed, input ready);
  modport sink (input valid, bus_addr, pc_advance, done_res, acc_out, neg_flag,
                zero_flag, page_crossed, output ready);
endinterface

// ----- rtl/ams_step.sv -----
`timescale 1ns / 1ps
// Next-step logic of the sequencer: one bus cycle's result and next state.
// Depends on ams_pkg.
module ams_step (
  input  ams_pkg::in_item_t   item,
  input  ams_pkg::seq_state_t state,
  output ams_pkg::out_item_t  result,
  output ams_pkg::seq_state_t state_next
);
  import ams_pkg::*;

  logic [7:0]  res;
  logic [15:0] base;
  logic [7:0]  idx;
  logic [15:0] sum;
  logic [7:0]  ptr_x;
  logic [7:0]  ptr_inc;
  logic        crossed;

  // Base for indexed and absolute final address: high byte just read
  assign base    = {item.bus_data, state.eff_addr[7:0]};
  assign idx     = (state.mode_latch == MODE_ABSX) ? item.x_index : item.y_index;
  assign sum     = base + {8'h00, idx};
  assign crossed = (sum & HI_MASK) != (base & HI_MASK);
  assign ptr_x   = state.pointer_word + item.x_index;   // wraps in page zero
  assign ptr_inc = state.pointer_word + 8'd1;
  assign res     = item.acc_in & item.bus_data;

  always_comb begin
    state_next          = state;
    result.bus_addr     = NO_ADDR;
    result.pc_advance   = 1'b0;
    result.done_res     = 1'b0;
    result.acc_out      = 8'h00;
    result.page_crossed = 1'b0;

    if (item.start_req) begin
      state_next.mode_latch    = mode_t'(item.mode);
      state_next.crossed_latch = 1'b0;
      state_next.step          = ST_OPND1;
      result.bus_addr          = item.pc;
      result.pc_advance        = 1'b1;
    end else begin
      case (state.step)
        ST_OPND1: begin
          case (state.mode_latch)
            MODE_IMM: begin
              result.done_res = 1'b1;
              result.acc_out  = res;
              state_next.step = ST_IDLE;
            end
            MODE_ZP: begin
              state_next.eff_addr = {8'h00, item.bus_data};
              result.bus_addr     = {8'h00, item.bus_data};
              state_next.step     = ST_OPERAND;
            end
            MODE_ZPX: begin
              state_next.eff_addr = {8'h00, item.bus_data + item.x_index};
              result.bus_addr     = {8'h00, item.bus_data};
              state_next.step     = ST_ISSUE;
            end
            MODE_ABS, MODE_ABSX, MODE_ABSY: begin
              state_next.eff_addr = {8'h00, item.bus_data};
              result.bus_addr     = item.pc;
              result.pc_advance   = 1'b1;
              state_next.step     = ST_ABS_HI;
            end
            MODE_INDX: begin
              state_next.pointer_word = item.bus_data;
              result.bus_addr         = {8'h00, item.bus_data};
              state_next.step         = ST_INDX_DM;
            end
            default: begin
              state_next.pointer_word = item.bus_data;
              result.bus_addr         = {8'h00, item.bus_data};
              state_next.step         = ST_PTR_LO;
            end
          endcase
        end
        ST_ISSUE: begin
          result.bus_addr = state.eff_addr;
          state_next.step = ST_OPERAND;
        end
        ST_ABS_HI, ST_PTR_HI: begin
          if ((state.step == ST_ABS_HI &&
               (state.mode_latch == MODE_ABSX || state.mode_latch == MODE_ABSY)) ||
              (state.step == ST_PTR_HI && state.mode_latch == MODE_INDY)) begin
            state_next.eff_addr = sum;
            if (crossed) begin
              // dummy read at old high byte, corrected address issued from ST_ISSUE
              state_next.crossed_latch = 1'b1;
              state_next.step          = ST_ISSUE;
              result.bus_addr          = (base & HI_MASK) | (sum & LO_MASK);
            end else begin
              state_next.step = ST_OPERAND;
              result.bus_addr = sum;
            end
          end else begin
            state_next.eff_addr = base;
            result.bus_addr     = base;
            state_next.step     = ST_OPERAND;
          end
        end
        ST_INDX_DM: begin
          state_next.pointer_word = ptr_x;
          result.bus_addr         = {8'h00, ptr_x};
          state_next.step         = ST_PTR_LO;
        end
        ST_PTR_LO: begin
          state_next.eff_addr = {8'h00, item.bus_data};
          result.bus_addr     = {8'h00, ptr_inc};
          state_next.step     = ST_PTR_HI;
        end
        ST_OPERAND: begin
          result.done_res     = 1'b1;
          result.acc_out      = res;
          result.page_crossed = state.crossed_latch;
          state_next.step     = ST_IDLE;
        end
        default: ;
      endcase
    end

    result.neg_flag  = result.done_res & result.acc_out[7];
    result.zero_flag = result.done_res && (result.acc_out == 8'h00);
  end
endmodule

// ----- rtl/and_addressing_mode_sequencer.sv -----
`timescale 1ns / 1ps
// Top level of the AND addressing-mode bus sequencer.
// Each transaction passes through an input register and then a result register.
// Throughput: one transaction per cycle while rsp.ready is high; the result register frees the input side.
// Reset (rst, synchronous): both stages empty, step idle, sequencer state cleared (data registers are not reset).
// Depends on ams_pkg, ams_if and ams_step.
module and_addressing_mode_sequencer (
  input  logic clk,
  input  logic rst,
  ams_in_if.sink    req,
  ams_out_if.source rsp
);
  import ams_pkg::*;

  logic       in_valid;
  in_item_t   in_item;
  seq_state_t state;
  seq_state_t state_next;
  out_item_t  result;
  logic       out_valid;
  out_item_t  out_item;
  logic       out_free;
  logic       advance;
  in_item_t   req_item;

  assign req_item = '{
    start_req: req.start_req, mode: req.mode, pc: req.pc, x_index: req.x_index,
    y_index: req.y_index, acc_in: req.acc_in, bus_data: req.bus_data
  };

  assign out_free  = !out_valid || rsp.ready;
  assign advance   = in_valid && out_free;
  assign req.ready = !in_valid || out_free;

  ams_step u_step (
    .item       (in_item),
    .state      (state),
    .result     (result),
    .state_next (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      state     <= STATE_RESET;
    end else begin
      if (req.valid && req.ready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_item <= req_item;
    end
    if (advance) begin
      out_item <= result;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.bus_addr     = out_item.bus_addr;
  assign rsp.pc_advance   = out_item.pc_advance;
  assign rsp.done_res     = out_item.done_res;
  assign rsp.acc_out      = out_item.acc_out;
  assign rsp.neg_flag     = out_item.neg_flag;
  assign rsp.zero_flag    = out_item.zero_flag;
  assign rsp.page_crossed = out_item.page_crossed;
endmodule
